// ===== hdl/tbbp_pkg.sv =====
// Shared types and constants for the two-button browse and power controller.
// Used by tbbp_csr, tbbp_step and the top level; depends on nothing.
`default_nettype none

package tbbp_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] CSR_RECEIVE_HOLD = 2'd0;
   localparam logic [1:0] CSR_BOTH_STABLE  = 2'd1;
   localparam logic [1:0] CSR_SHUTDOWN     = 2'd2;
   localparam logic [1:0] CSR_DEBOUNCE     = 2'd3;

   localparam logic [15:0] RECEIVE_HOLD_RESET = 16'd200;
   localparam logic [7:0]  BOTH_STABLE_RESET  = 8'd10;
   localparam logic [15:0] SHUTDOWN_RESET     = 16'd500;
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd25;

   // pending browse mask bits
   localparam logic [1:0] MASK_NEXT = 2'b01;
   localparam logic [1:0] MASK_PREV = 2'b10;

   localparam int REQ_WIDTH = 48;
   localparam int RSP_WIDTH = 16;

   typedef struct packed {
      logic [15:0] rx_hold_limit;
      logic [7:0]  both_stable_ticks;
      logic [15:0] shutdown_ticks;
      logic [7:0]  debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic        next_pressed;
      logic        prev_pressed;
      logic [31:0] now_ms;
      logic [7:0]  pattern_count;
      logic        frame_done;
   } item_type;

   typedef struct packed {
      logic [15:0] hold_count;
      logic        hold_latched;
      logic        receive_mode;
      logic [1:0]  pending_mask;
      logic [31:0] debounce_deadline;
      logic [7:0]  selected_index;
      logic [7:0]  both_stable_count;
      logic [15:0] shutdown_count;
   } state_type;

   typedef struct packed {
      logic       receive_on;
      logic       receive_begin;
      logic       receive_end;
      logic       show_pattern;
      logic [7:0] pattern_index;
      logic       show_empty;
      logic       shutdown_request;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/tbbp_csr.sv =====
// Configuration register file for the browse and power controller.
// Depends on tbbp_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module tbbp_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             write_en,
   input  wire logic [1:0]       write_index,
   input  wire logic [15:0]      write_data,
   output tbbp_pkg::cfg_type     cfg
);

   tbbp_pkg::cfg_type cfg_ff;
   tbbp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (write_index)
            tbbp_pkg::CSR_RECEIVE_HOLD: cfg_in.rx_hold_limit     = write_data;
            tbbp_pkg::CSR_BOTH_STABLE:  cfg_in.both_stable_ticks = write_data[7:0];
            tbbp_pkg::CSR_SHUTDOWN:     cfg_in.shutdown_ticks    = write_data;
            tbbp_pkg::CSR_DEBOUNCE:     cfg_in.debounce_ms       = write_data[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_hold_limit     <= tbbp_pkg::RECEIVE_HOLD_RESET;
         cfg_ff.both_stable_ticks <= tbbp_pkg::BOTH_STABLE_RESET;
         cfg_ff.shutdown_ticks    <= tbbp_pkg::SHUTDOWN_RESET;
         cfg_ff.debounce_ms       <= tbbp_pkg::DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/tbbp_step.sv =====
// Per-tick next-state and result logic of the browse and power controller.
// Purely combinational; depends on tbbp_pkg for the item, state and result types.
`default_nettype none

module tbbp_step (
   input  wire tbbp_pkg::cfg_type    cfg,
   input  wire tbbp_pkg::item_type   item,
   input  wire tbbp_pkg::state_type  cur,
   output tbbp_pkg::state_type       nxt,
   output tbbp_pkg::result_type      res
);

   logic [31:0] deadline_new;
   logic [31:0] since_deadline;
   logic [7:0]  index_up;

   assign deadline_new = item.now_ms + {24'd0, cfg.debounce_ms};
   assign index_up     = cur.selected_index + 8'd1;

   always_comb begin
      nxt            = cur;
      res            = '0;
      since_deadline = '0;

      // long hold of the previous button toggles receive mode once per hold
      if (item.prev_pressed) begin
         if (cur.hold_count < cfg.rx_hold_limit) begin
            nxt.hold_count = cur.hold_count + 16'd1;
         end else if (!cur.hold_latched) begin
            nxt.receive_mode      = !cur.receive_mode;
            res.receive_begin     = !cur.receive_mode;
            res.receive_end       = cur.receive_mode;
            nxt.hold_latched      = 1'b1;
            nxt.pending_mask      = '0;
            nxt.debounce_deadline = deadline_new;
         end
      end else begin
         nxt.hold_count   = '0;
         nxt.hold_latched = 1'b0;
      end

      // browse outside the debounce window, acted on at release
      since_deadline = item.now_ms - nxt.debounce_deadline;
      if (!since_deadline[31]) begin
         if (item.next_pressed) nxt.pending_mask = nxt.pending_mask | tbbp_pkg::MASK_NEXT;
         if (item.prev_pressed) nxt.pending_mask = nxt.pending_mask | tbbp_pkg::MASK_PREV;
         if (!item.next_pressed && !item.prev_pressed) begin
            if (nxt.pending_mask == tbbp_pkg::MASK_NEXT ||
                nxt.pending_mask == tbbp_pkg::MASK_PREV) begin
               if (item.pattern_count == 8'd0) begin
                  nxt.selected_index = '0;
                  res.show_empty     = 1'b1;
               end else begin
                  if (nxt.pending_mask == tbbp_pkg::MASK_NEXT) begin
                     // wrap when the stepped index reaches the count (index 255 wraps too)
                     nxt.selected_index = (cur.selected_index == 8'hFF ||
                                           index_up >= item.pattern_count) ? 8'd0 : index_up;
                  end else if (cur.selected_index == 8'd0) begin
                     nxt.selected_index = item.pattern_count - 8'd1;
                  end else begin
                     nxt.selected_index = cur.selected_index - 8'd1;
                  end
                  res.show_pattern = 1'b1;
               end
               nxt.debounce_deadline = deadline_new;
            end
            nxt.pending_mask = '0;
         end
      end

      // completed frame ends receive mode
      if (nxt.receive_mode && item.frame_done) begin
         nxt.receive_mode   = 1'b0;
         nxt.selected_index = '0;
         res.receive_end    = 1'b1;
      end

      // both-button shutdown hold
      if (item.next_pressed && item.prev_pressed) begin
         if (cur.both_stable_count < cfg.both_stable_ticks) begin
            nxt.both_stable_count = cur.both_stable_count + 8'd1;
         end else if (cur.shutdown_count < cfg.shutdown_ticks) begin
            nxt.shutdown_count = cur.shutdown_count + 16'd1;
         end else begin
            res.shutdown_request  = 1'b1;
            nxt.shutdown_count    = '0;
            nxt.both_stable_count = '0;
         end
      end else begin
         nxt.both_stable_count = '0;
         nxt.shutdown_count    = '0;
      end

      res.receive_on    = nxt.receive_mode;
      res.pattern_index = nxt.selected_index;
   end

endmodule

`default_nettype wire

// ===== hdl/two_button_browse_power_controller.sv =====
// Top level of the two-button browse and power controller: request register,
// controller state, per-tick logic (tbbp_step), config registers (tbbp_csr), response register.
// Depends on tbbp_pkg, tbbp_csr and tbbp_step.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   req     | in        | req_tvalid/req_tready  | req_tdata[47:0], one poll tick
//   rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata[15:0], one result per tick
//   csr     | in        | csr_valid/csr_ready    | csr_index[1:0], csr_data[15:0]
//
// Each request is held in the request register, and its response is registered in
// the response register; one request per cycle is sustained while rsp_tready is high.
// The per-tick logic between the two registers is one 32-bit add and compare path
// plus two 16-bit counters and one 8-bit counter. Reset clears all controller state
// and loads the register defaults. When rsp_tready is low and the response register is full,
// the response holds, the request register holds its item and only then does req_tready drop.
// The configuration port is always ready.
`default_nettype none

module two_button_browse_power_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: [0] next_pressed, [1] prev_pressed, [33:2] now_ms,
   //          [41:34] pattern_count, [42] frame_done, [47:43] zero
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [tbbp_pkg::REQ_WIDTH-1:0] req_tdata,
   // response: [0] receive_on, [1] receive_begin, [2] receive_end, [3] show_pattern,
   //           [11:4] pattern_index, [12] show_empty, [13] shutdown_request, [15:14] zero
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [tbbp_pkg::RSP_WIDTH-1:0] rsp_tdata,
   // configuration write
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   tbbp_pkg::cfg_type    cfg;
   tbbp_pkg::item_type   item_ff;
   tbbp_pkg::item_type   item_in;
   tbbp_pkg::state_type  state_ff;
   tbbp_pkg::state_type  state_in;
   tbbp_pkg::result_type result_in;
   tbbp_pkg::result_type result_ff;
   logic                 item_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_take;

   assign csr_ready = 1'b1;

   tbbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid),
      .write_index (csr_index),
      .write_data  (csr_data),
      .cfg         (cfg)
   );

   // unpack the request
   always_comb begin
      item_in.next_pressed  = req_tdata[0];
      item_in.prev_pressed  = req_tdata[1];
      item_in.now_ms        = req_tdata[33:2];
      item_in.pattern_count = req_tdata[41:34];
      item_in.frame_done    = req_tdata[42];
   end

   // advance the held item when the response register is free or being drained
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   tbbp_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         if (req_take) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        result_ff.shutdown_request,
                        result_ff.show_empty,
                        result_ff.pattern_index,
                        result_ff.show_pattern,
                        result_ff.receive_end,
                        result_ff.receive_begin,
                        result_ff.receive_on};

endmodule

`default_nettype wire
